// ===== sv/swtb_pkg.sv =====
package swtb_pkg;

   localparam int NUM_TIMERS = 3;
   localparam int COUNT_BITS = 20;
   localparam int INDEX_BITS = 2;
   localparam int ID_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CMP_BITS = (ID_BITS > INDEX_BITS) ? ID_BITS : INDEX_BITS;

   localparam int RESET_COUNT_FIRST = 500;
   localparam int RESET_COUNT_OTHER = 30000;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_LOAD  = 2'd3
   } mode_type;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [NUM_TIMERS-1:0] mask_type;

   typedef struct packed {
      logic                  valid;
      mode_type              mode;
      logic [INDEX_BITS-1:0] timer_index;
      count_type             load_value;
      mask_type              expired_mask;
      mask_type              running_mask;
   } token_type;

   function automatic count_type reset_count(int unsigned t);
      count_type v;
      v = (t == 0) ? COUNT_BITS'(RESET_COUNT_FIRST) : COUNT_BITS'(RESET_COUNT_OTHER);
      return v;
   endfunction

endpackage

// ===== sv/swtb_req_if.sv =====
interface swtb_req_if
   import swtb_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            mode;
   logic [INDEX_BITS-1:0] timer_index;
   count_type             load_value;

   modport source (output valid, output mode, output timer_index, output load_value,
                   input ready);
   modport sink (input valid, input mode, input timer_index, input load_value,
                 output ready);
endinterface

// ===== sv/swtb_rsp_if.sv =====
interface swtb_rsp_if
   import swtb_pkg::*;
   ();
   logic     valid;
   logic     ready;
   mask_type expired_mask;
   mask_type running_mask;

   modport source (output valid, output expired_mask, output running_mask, input ready);
   modport sink (input valid, input expired_mask, input running_mask, output ready);
endinterface

// ===== sv/swtb_cell.sv =====
module swtb_cell
   import swtb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ID_BITS-1:0] cell_id,
   input  count_type          reset_value,
   input  logic               auto_restart,
   input  token_type          tok_in,
   output token_type          tok_out
);

   logic      running_ff, running_in;
   count_type count_ff, count_in;
   count_type reload_ff, reload_in;
   token_type tok_ff, tok_in_next;
   logic      hit;
   logic      expired;
   count_type count_dec;

   assign hit = (CMP_BITS'(tok_in.timer_index) == CMP_BITS'(cell_id));
   assign count_dec = count_ff - COUNT_BITS'(1);

   always_comb begin
      running_in = running_ff;
      count_in = count_ff;
      reload_in = reload_ff;
      expired = 1'b0;
      if (tok_in.valid) begin
         unique case (tok_in.mode)
            MODE_TICK: begin
               if (running_ff && (count_ff != '0)) begin
                  if (count_dec == '0) begin
                     count_in = reload_ff;
                     expired = 1'b1;
                     running_in = auto_restart;
                  end else begin
                     count_in = count_dec;
                  end
               end
            end
            MODE_START: begin
               if (hit) begin
                  count_in = reload_ff;
                  running_in = 1'b1;
               end
            end
            MODE_STOP: begin
               if (hit) begin
                  running_in = 1'b0;
               end
            end
            MODE_LOAD: begin
               if (hit && (tok_in.load_value != '0)) begin
                  reload_in = tok_in.load_value;
                  count_in = tok_in.load_value;
                  running_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      tok_in_next = tok_in;
      tok_in_next.expired_mask[cell_id] = expired;
      tok_in_next.running_mask[cell_id] = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= (cell_id == '0);
         count_ff <= reset_value;
         reload_ff <= reset_value;
         tok_ff <= '0;
      end else begin
         running_ff <= running_in;
         count_ff <= count_in;
         reload_ff <= reload_in;
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== sv/software_timer_bank_top.sv =====
// A transaction's command token moves through the timer cells one per cycle, each cell registering it;
// the response is registered after the last cell.
// A new transaction is accepted only once the previous token has left the last cell and the response register is free.
// Reset is synchronous and active high; it restores timer 0 running with 500 counts, the other
// timers stopped with 30000 counts, and the auto-restart mask to timer 0 only.
module software_timer_bank_top
   import swtb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   swtb_req_if.sink   req,
   swtb_rsp_if.source rsp,
   input  logic     csr_we,
   input  mask_type csr_wdata
);

   mask_type  auto_restart_ff, auto_restart_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;
   mask_type  rsp_expired_ff, rsp_running_ff;
   logic      accept;
   token_type tok_chain [NUM_TIMERS+1];

   assign req.ready = !busy_ff && (!rsp_valid_ff || rsp.ready);
   assign accept = req.valid && req.ready;

   always_comb begin
      tok_chain[0].valid = accept;
      tok_chain[0].mode = mode_type'(req.mode);
      tok_chain[0].timer_index = req.timer_index;
      tok_chain[0].load_value = req.load_value;
      tok_chain[0].expired_mask = '0;
      tok_chain[0].running_mask = '0;
   end

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      swtb_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_id      (ID_BITS'(g)),
         .reset_value  (reset_count(g)),
         .auto_restart (auto_restart_ff[g]),
         .tok_in       (tok_chain[g]),
         .tok_out      (tok_chain[g+1])
      );
   end

   always_comb begin
      auto_restart_in = csr_we ? csr_wdata : auto_restart_ff;
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tok_chain[NUM_TIMERS].valid) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (tok_chain[NUM_TIMERS].valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_restart_ff <= NUM_TIMERS'(1);
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         auto_restart_ff <= auto_restart_in;
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_chain[NUM_TIMERS].valid) begin
         rsp_expired_ff <= tok_chain[NUM_TIMERS].expired_mask;
         rsp_running_ff <= tok_chain[NUM_TIMERS].running_mask;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.expired_mask = rsp_expired_ff;
   assign rsp.running_mask = rsp_running_ff;

endmodule

// ===== sv/swtb_checker.sv =====
module swtb_checker
   import swtb_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic req_accept;

   assign req_accept = req_valid && req_ready;

   // A response that waits on the sink must not be withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // Only one transaction is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("request accepted while busy");

   // The output stage is empty while a transaction moves through the timers.
   a_out_drained: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !rsp_valid)
      else $error("stale response present after request");

   // Every request produces its response once its token has passed all timer cells and the response register.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##(NUM_TIMERS + 1) rsp_valid)
      else $error("response missing after request");

endmodule

bind software_timer_bank_top swtb_checker u_swtb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready)
);
